/* hw/rtl/rrwt_pkg.sv */
// Region refresh wear tracker: shared request/result types, FSM encoding and constants.
// No dependencies; imported by region_refresh_wear_tracker.
package rrwt_pkg;

  localparam int unsigned IdInW  = 8;
  localparam int unsigned CntW   = 16;
  localparam int unsigned SlotW  = 4;
  localparam logic [CntW-1:0] ThresholdReset = 16'd50;

  localparam logic FuncPaint   = 1'b0;
  localparam logic FuncRefresh = 1'b1;

  typedef struct packed {
    logic             func;
    logic [IdInW-1:0] region_id;
    logic             first_of_plan;
  } in_req_t;

  typedef struct packed {
    logic             processed;
    logic             tracked;
    logic [SlotW-1:0] slot;
    logic [CntW-1:0]  paint_count;
    logic             recover_now;
  } out_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

endpackage

/* hw/rtl/region_refresh_wear_tracker.sv */
// Region refresh wear tracker top level: region table memories, scan FSM, config register.
// Depends on rrwt_pkg.
//
// Usage:
//   in_valid/in_stall/in_data carry one request (paint or full refresh). A request is taken
//   when in_valid is high and in_stall is low; in_stall is high while a request is in work.
//   out_valid/out_stall/out_data carry one result per request, held until out_stall is low.
//   cfg_valid/cfg_ready/cfg_data write recovery_threshold; cfg_ready is always high. Write it
//   only while no request is in work.
// Timing:
//   A paint request scans the table one slot per cycle through the synchronous read port
//   of the region/count memories, then writes the matching or a free slot in the cycle the scan ends.
//   A refresh or a skipped paint goes from the request straight to the finish state; a paint
//   passes through the scan state first. The next request is taken only once the result is
//   in the output register, so a new request never overlaps the one in work.
// Reset:
//   rst_n (synchronous, active low) empties the table, clears plan state and sets the
//   threshold to 50. The memories are not cleared; only slots below the fill count are read.
// Stall:
//   A finished result waits in an internal register until the output register is free; the
//   block takes no new request until then.
module region_refresh_wear_tracker
  import rrwt_pkg::*;
#(
  parameter int unsigned MAX_REGIONS    = 16,
  parameter int unsigned REGION_ID_BITS = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  in_req_t         in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output out_rsp_t        out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [CntW-1:0] cfg_data
);

  localparam int unsigned IdW = (REGION_ID_BITS < IdInW) ? REGION_ID_BITS : IdInW;
  localparam int unsigned CW  = $clog2(MAX_REGIONS + 1);
  localparam int unsigned AW  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_REGIONS);

  logic [IdW-1:0]  mem_region [MAX_REGIONS];
  logic [CntW-1:0] mem_count  [MAX_REGIONS];

  state_t          state_r, state_nxt;
  logic [CW-1:0]   used_r, used_nxt;
  logic [CW-1:0]   plan_rec_r, plan_rec_nxt;
  logic            halted_r, halted_nxt;
  logic [CntW-1:0] thr_r;
  logic [IdW-1:0]  rid_r, rid_nxt;
  logic [CW-1:0]   scan_idx_r, scan_idx_nxt;
  logic            pend_r, pend_nxt;
  logic [CW-1:0]   pend_idx_r, pend_idx_nxt;
  out_rsp_t        res_r, res_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_rsp_t        out_data_r, out_data_nxt;

  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [IdW-1:0]  reg_q;
  logic [CntW-1:0] cnt_q;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [IdW-1:0]  wr_region;
  logic [CntW-1:0] wr_count;

  logic            in_acc;
  logic            out_free;
  logic            halted_eff;
  logic [CW-1:0]   plan_rec_eff;
  logic            issue;
  logic            hit;
  logic            tracked;
  logic [CW-1:0]   slot_idx;
  logic [CntW-1:0] new_cnt;
  logic            recover;
  logic [CntW-1:0] final_cnt;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  assign halted_eff   = in_data.first_of_plan ? 1'b0 : halted_r;
  assign plan_rec_eff = in_data.first_of_plan ? '0 : plan_rec_r;

  assign issue   = (scan_idx_r < used_r);
  assign hit     = pend_r && (reg_q == rid_r);
  assign rd_en   = (state_r == ST_SCAN) && issue && !hit;
  assign rd_addr = scan_idx_r[AW-1:0];

  // Slot decision in the cycle the scan ends
  always_comb begin
    tracked  = 1'b0;
    slot_idx = '0;
    new_cnt  = '0;
    if (hit) begin
      tracked  = 1'b1;
      slot_idx = pend_idx_r;
      new_cnt  = cnt_q + 16'd1;
    end else if (used_r < MaxCnt) begin
      tracked  = 1'b1;
      slot_idx = used_r;
      new_cnt  = 16'd1;
    end
    recover   = tracked && (plan_rec_r < MaxCnt) && (new_cnt >= thr_r);
    final_cnt = recover ? '0 : new_cnt;
  end

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    plan_rec_nxt  = plan_rec_r;
    halted_nxt    = halted_r;
    rid_nxt       = rid_r;
    scan_idx_nxt  = scan_idx_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = slot_idx[AW-1:0];
    wr_region     = rid_r;
    wr_count      = final_cnt;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_nxt = '0;
          if (in_data.func == FuncRefresh) begin
            used_nxt  = '0;
            state_nxt = ST_FIN;
          end else begin
            plan_rec_nxt = plan_rec_eff;
            halted_nxt   = halted_eff;
            if (halted_eff) begin
              state_nxt = ST_FIN;
            end else begin
              rid_nxt      = in_data.region_id[IdW-1:0];
              scan_idx_nxt = '0;
              pend_nxt     = 1'b0;
              state_nxt    = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (hit || !issue) begin
          res_nxt.processed   = 1'b1;
          res_nxt.tracked     = tracked;
          res_nxt.slot        = SlotW'(slot_idx);
          res_nxt.paint_count = tracked ? final_cnt : '0;
          res_nxt.recover_now = recover;
          wr_en = tracked;
          if (tracked && !hit) begin
            used_nxt = CW'(used_r + 1'b1);
          end
          if (plan_rec_r >= MaxCnt) begin
            halted_nxt = 1'b1;
          end else if (recover) begin
            plan_rec_nxt = CW'(plan_rec_r + 1'b1);
          end
          state_nxt = ST_FIN;
        end else begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = scan_idx_r;
          scan_idx_nxt = CW'(scan_idx_r + 1'b1);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      reg_q <= mem_region[rd_addr];
      cnt_q <= mem_count[rd_addr];
    end
    if (wr_en) begin
      mem_region[wr_addr] <= wr_region;
      mem_count[wr_addr]  <= wr_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      plan_rec_r  <= '0;
      halted_r    <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      thr_r       <= ThresholdReset;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      plan_rec_r  <= plan_rec_nxt;
      halted_r    <= halted_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    rid_r      <= rid_nxt;
    scan_idx_r <= scan_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
